// ----- sv/cbd_pkg.sv -----
// Shared types, constants and helper functions for the chunked body decoder.
// Used by every module of the decoder; depends on nothing else.
`default_nettype none

package cbd_pkg;

	localparam int SIZE_WIDTH_DEFAULT = 32;
	localparam int LINE_LIMIT_DEFAULT = 31;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 32;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CHUNKED_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTENT_LENGTH = 1'd1;

	// Characters that matter on the size line.
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_LOW_X = 8'h78;
	localparam logic [BYTE_W-1:0] CH_UP_X  = 8'h58;

	localparam logic [1:0] TRAILER_BYTES = 2'd2;

	typedef enum logic [1:0] {
		PH_LINE,
		PH_DATA,
		PH_TRAIL
	} phase_t;

	typedef enum logic [1:0] {
		HX_SPACE,
		HX_ZERO,
		HX_DIGITS,
		HX_STOP
	} hex_step_t;

	typedef struct packed {
		logic              has_byte;
		logic [BYTE_W-1:0] out_byte;
		logic              is_last;
		logic [LEN_W-1:0]  body_length;
	} result_t;

	function automatic logic is_hex_digit(input logic [BYTE_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_digit_value(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] v;
		v = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
	endfunction

endpackage

`default_nettype wire

// ----- sv/cbd_hex_parse.sv -----
// Next state of the base-16 size parser for one size-line character.
// Depends on cbd_pkg.
`default_nettype none

module cbd_hex_parse #(
	parameter int SIZE_WIDTH = cbd_pkg::SIZE_WIDTH_DEFAULT
) (
	input  wire logic [cbd_pkg::BYTE_W-1:0] ch,
	input  wire cbd_pkg::hex_step_t         step,
	input  wire logic [SIZE_WIDTH-1:0]      acc,
	output cbd_pkg::hex_step_t              step_next,
	output logic [SIZE_WIDTH-1:0]           acc_next
);
	import cbd_pkg::*;

	logic                  digit;
	logic [3:0]            dval;
	logic [SIZE_WIDTH-1:0] acc_digit;

	assign digit = is_hex_digit(ch);
	assign dval  = hex_digit_value(ch);

	// Any bit in the top nibble means the shift would overflow, so saturate.
	assign acc_digit = (|acc[SIZE_WIDTH-1:SIZE_WIDTH-4]) ? {SIZE_WIDTH{1'b1}}
		: {acc[SIZE_WIDTH-5:0], dval};

	always_comb begin
		step_next = step;
		acc_next  = acc;
		unique case (step)
			HX_SPACE: begin
				if (is_blank(ch)) begin
					step_next = HX_SPACE;
				end else if (ch == CH_ZERO) begin
					step_next = HX_ZERO;
				end else if (digit) begin
					acc_next  = acc_digit;
					step_next = HX_DIGITS;
				end else begin
					step_next = HX_STOP;
				end
			end
			HX_ZERO: begin
				if (ch == CH_LOW_X || ch == CH_UP_X) begin
					step_next = HX_DIGITS;
				end else if (digit) begin
					acc_next  = acc_digit;
					step_next = HX_DIGITS;
				end else begin
					step_next = HX_STOP;
				end
			end
			HX_DIGITS: begin
				if (digit) begin
					acc_next = acc_digit;
				end else begin
					step_next = HX_STOP;
				end
			end
			HX_STOP: begin
				step_next = HX_STOP;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/cbd_step.sv -----
// Decoder state and the combinational update for one item, registered while step_en is high.
// Depends on cbd_pkg and cbd_hex_parse.
`default_nettype none

module cbd_step #(
	parameter int SIZE_WIDTH = cbd_pkg::SIZE_WIDTH_DEFAULT,
	parameter int LINE_LIMIT = cbd_pkg::LINE_LIMIT_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step_en,
	input  wire logic [cbd_pkg::BYTE_W-1:0] item_byte,
	input  wire logic                       item_eos,
	input  wire logic                       chunked_mode,
	input  wire logic [cbd_pkg::LEN_W-1:0]  content_length,
	output logic                            res_valid,
	output cbd_pkg::result_t                res
);
	import cbd_pkg::*;

	localparam int LCW = $clog2(LINE_LIMIT + 1);

	phase_t                phase_q, phase_d;
	hex_step_t             hex_q, hex_d, hex_parsed;
	logic [LCW-1:0]        line_q, line_d, line_inc;
	logic [SIZE_WIDTH-1:0] acc_q, acc_d, acc_parsed, size_end;
	logic [SIZE_WIDTH-1:0] rem_q, rem_d, rem_dec;
	logic [1:0]            trail_q, trail_d, trail_dec;
	logic [LEN_W-1:0]      del_q, del_d, del_inc;
	logic                  fin_q, fin_d;

	logic is_lf, is_cr, line_end, plain_over, plain_last;

	cbd_hex_parse #(.SIZE_WIDTH(SIZE_WIDTH)) u_hex (
		.ch        (item_byte),
		.step      (hex_q),
		.acc       (acc_q),
		.step_next (hex_parsed),
		.acc_next  (acc_parsed)
	);

	assign is_lf     = (item_byte == CH_LF);
	assign is_cr     = (item_byte == CH_CR);
	assign line_inc  = line_q + 1'b1;
	assign line_end  = is_lf || (!is_cr && (line_inc >= LCW'(LINE_LIMIT)));
	// A newline ends the line without feeding the parser.
	assign size_end  = is_lf ? acc_q : acc_parsed;
	assign rem_dec   = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
	assign trail_dec = (trail_q != 2'd0) ? trail_q - 1'b1 : trail_q;
	assign del_inc   = (del_q != {LEN_W{1'b1}}) ? del_q + 1'b1 : del_q;

	assign plain_over = (content_length != '0) && (del_q >= content_length);
	assign plain_last = (content_length != '0) && (del_inc >= content_length);

	// Next state.
	always_comb begin
		phase_d = phase_q;
		hex_d   = hex_q;
		line_d  = line_q;
		acc_d   = acc_q;
		rem_d   = rem_q;
		trail_d = trail_q;
		del_d   = del_q;
		fin_d   = fin_q;
		if (!fin_q) begin
			if (item_eos) begin
				fin_d = 1'b1;
			end else if (!chunked_mode) begin
				if (plain_over) begin
					fin_d = 1'b1;
				end else begin
					del_d = del_inc;
					fin_d = plain_last;
				end
			end else begin
				unique case (phase_q)
					PH_DATA: begin
						del_d = del_inc;
						rem_d = rem_dec;
						if (rem_dec == '0) begin
							phase_d = PH_TRAIL;
							trail_d = TRAILER_BYTES;
						end
					end
					PH_TRAIL: begin
						trail_d = trail_dec;
						if (trail_dec == 2'd0) begin
							phase_d = PH_LINE;
						end
					end
					PH_LINE: begin
						if (!is_cr && !is_lf) begin
							hex_d  = hex_parsed;
							acc_d  = acc_parsed;
							line_d = line_inc;
						end
						if (line_end) begin
							line_d = '0;
							hex_d  = HX_SPACE;
							acc_d  = '0;
							if (size_end == '0) begin
								fin_d = 1'b1;
							end else begin
								rem_d   = size_end;
								phase_d = PH_DATA;
							end
						end
					end
					default: begin
						phase_d = PH_LINE;
					end
				endcase
			end
		end
	end

	// Result for this item.
	always_comb begin
		res_valid        = 1'b0;
		res.has_byte     = 1'b0;
		res.out_byte     = '0;
		res.is_last      = 1'b0;
		res.body_length  = del_d;
		if (!fin_q) begin
			if (item_eos) begin
				res_valid   = 1'b1;
				res.is_last = 1'b1;
			end else if (!chunked_mode) begin
				res_valid = 1'b1;
				if (plain_over) begin
					res.is_last = 1'b1;
				end else begin
					res.has_byte = 1'b1;
					res.out_byte = item_byte;
					res.is_last  = plain_last;
				end
			end else if (phase_q == PH_DATA) begin
				res_valid    = 1'b1;
				res.has_byte = 1'b1;
				res.out_byte = item_byte;
			end else if (phase_q == PH_LINE && line_end && size_end == '0) begin
				res_valid   = 1'b1;
				res.is_last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE;
			hex_q   <= HX_SPACE;
			line_q  <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			trail_q <= 2'd0;
			del_q   <= '0;
			fin_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			hex_q   <= hex_d;
			line_q  <= line_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			trail_q <= trail_d;
			del_q   <= del_d;
			fin_q   <= fin_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/chunked_body_decoder.sv -----
// Top level of the HTTP response body decoder: input stage, result stage, registers.
// Depends on cbd_pkg and cbd_step.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        in         in_valid / in_stall       in_byte, end_of_stream
// out       out        out_valid / out_stall     has_byte, out_byte, is_last, body_length
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The whole decode step of an item is done in the input stage; when the item advances, its
// result, if any, is registered; the block takes one item per cycle while in_stall is low.
// An item that causes no result leaves the input stage even while the result stalls.
// Only an item that has a result waits, and only while the result register is held.
// Reset (arst_n low) clears all decoder state, config and valid flags; no clearing pass.
// The configuration port is always ready; writes are taken in any cycle.

module chunked_body_decoder #(
	parameter int SIZE_WIDTH = cbd_pkg::SIZE_WIDTH_DEFAULT,
	parameter int LINE_LIMIT = cbd_pkg::LINE_LIMIT_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [cbd_pkg::BYTE_W-1:0]    in_byte,
	input  wire logic                          end_of_stream,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               has_byte,
	output logic [cbd_pkg::BYTE_W-1:0]         out_byte,
	output logic                               is_last,
	output logic [cbd_pkg::LEN_W-1:0]          body_length,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [cbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cbd_pkg::LEN_W-1:0]     cfg_data
);
	import cbd_pkg::*;

	// Configuration registers.
	logic             chunked_mode_q;
	logic [LEN_W-1:0] content_length_q;

	// Input stage holds the item being decoded.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eos_s1;

	// Result stage.
	logic    valid_s2;
	result_t res_s2;

	logic    res_valid;
	result_t res;
	logic    advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q   <= 1'b0;
			content_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CHUNKED_MODE:   chunked_mode_q   <= cfg_data[0];
				REG_CONTENT_LENGTH: content_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The item in the input stage moves on unless it has a result and the
	// result register is full and held.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall || !res_valid);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_stream;
		end
	end

	cbd_step #(
		.SIZE_WIDTH (SIZE_WIDTH),
		.LINE_LIMIT (LINE_LIMIT)
	) u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (advance),
		.item_byte      (byte_s1),
		.item_eos       (eos_s1),
		.chunked_mode   (chunked_mode_q),
		.content_length (content_length_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res_valid) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign has_byte    = res_s2.has_byte;
	assign out_byte    = res_s2.out_byte;
	assign is_last     = res_s2.is_last;
	assign body_length = res_s2.body_length;

`ifndef SYNTHESIS
	// A result without a payload byte carries a zero byte.
	a_empty_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.has_byte) |-> (res_s2.out_byte == '0))
		else $error("result without payload byte has nonzero out_byte");

	// Every delivered payload byte has been counted.
	a_byte_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.has_byte) |-> (res_s2.body_length != '0))
		else $error("payload byte delivered with zero body_length");

	// The input side is held only by an item waiting in the input stage
	// behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall && res_valid))
		else $error("input stalled without a waiting result");
`endif

endmodule

`default_nettype wire
